/* src/av1shl_pkg.sv */
package av1shl_pkg;

    localparam int unsigned POS_W   = 25;
    localparam int unsigned START_W = 24;
    localparam int unsigned RUN_W   = 2;
    localparam int unsigned TYPE_W  = 5;

    localparam logic [POS_W-1:0]  MAX_STREAM_BYTES = 25'h100_0000;
    localparam logic [TYPE_W-1:0] OBU_TYPE_MASK    = 5'h1F;
    localparam int unsigned       OBU_TYPE_SHIFT   = 3;
    localparam logic [TYPE_W-1:0] OBU_SEQ_HEADER   = 5'd1;
    localparam logic [RUN_W-1:0]  ZERO_RUN_MAX     = 2'd3;
    localparam logic [RUN_W-1:0]  ZERO_RUN_CODE    = 2'd2;
    localparam logic [7:0]        BYTE_ZERO        = 8'h00;
    localparam logic [7:0]        BYTE_ONE         = 8'h01;

    typedef enum logic [1:0] {
        PH_SEARCHING = 2'd0,
        PH_IN_SPAN   = 2'd1,
        PH_DONE      = 2'd2
    } t_phase;

    typedef struct packed {
        logic               header_found;
        logic [START_W-1:0] span_start;
        logic [POS_W-1:0]   span_end;
        logic               too_long;
    } t_result;

endpackage

/* src/av1shl_in_if.sv */
interface av1shl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       last_byte;

    modport source (output valid, output stream_byte, output last_byte, input ready);
    modport sink   (input valid, input stream_byte, input last_byte, output ready);
endinterface

/* src/av1shl_out_if.sv */
interface av1shl_out_if;
    logic                               valid;
    logic                               ready;
    logic                               header_found;
    logic [av1shl_pkg::START_W-1:0]     span_start;
    logic [av1shl_pkg::POS_W-1:0]       span_end;
    logic                               too_long;

    modport source (output valid, output header_found, output span_start,
                    output span_end, output too_long, input ready);
    modport sink   (input valid, input header_found, input span_start,
                    input span_end, input too_long, output ready);
endinterface

/* src/av1_sequence_header_locator.sv */
// Scans an Annex-B style AV1 byte stream, one word (byte) per cycle, for start codes
// (00 00 01 or 00 00 00 01) confirmed by a following header byte, and reports the
// span of the first sequence-header OBU: its start code offset and the offset of the
// next confirmed start code, or the stream length. One result word is given per
// stream, for the word flagged last_byte, behind the input and output registers.
// A word is taken every cycle; the only stall is a finished result still waiting
// in the output register when the next stream's last word is due. Streams beyond
// 2^24 bytes set too_long; the byte counter saturates there. No startup delay.
module av1_sequence_header_locator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    av1shl_in_if.sink     i_in,
    av1shl_out_if.source  o_out
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    logic                 r_out_valid;
    av1shl_pkg::t_result  r_out;

    logic                 out_free;
    logic                 step;
    av1shl_pkg::t_result  result;

    assign out_free   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && (!r_in_last || out_free);
    assign i_in.ready = !r_in_valid || step;

    av1shl_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (step && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.stream_byte;
            r_in_last <= i_in.last_byte;
        end
        if (step && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.header_found = r_out.header_found;
    assign o_out.span_start   = r_out.span_start;
    assign o_out.span_end     = r_out.span_end;
    assign o_out.too_long     = r_out.too_long;

endmodule

/* src/av1shl_scan.sv */
module av1shl_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output av1shl_pkg::t_result  o_result
);

    logic [av1shl_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [av1shl_pkg::RUN_W-1:0]   r_zero_run, n_zero_run;
    logic                           r_pending, n_pending;
    logic [av1shl_pkg::START_W-1:0] r_pending_start, n_pending_start;
    av1shl_pkg::t_phase             r_phase, n_phase;
    logic [av1shl_pkg::START_W-1:0] r_found_start, n_found_start;
    logic [av1shl_pkg::POS_W-1:0]   r_found_end, n_found_end;
    logic                           r_ovf, n_ovf;

    logic                            in_range;
    logic [av1shl_pkg::TYPE_W-1:0]   hdr_type;
    logic [av1shl_pkg::START_W-1:0]  back_off;
    logic                            found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos           <= '0;
            r_zero_run      <= '0;
            r_pending       <= 1'b0;
            r_pending_start <= '0;
            r_phase         <= av1shl_pkg::PH_SEARCHING;
            r_found_start   <= '0;
            r_found_end     <= '0;
            r_ovf           <= 1'b0;
        end else begin
            r_pos           <= n_pos;
            r_zero_run      <= n_zero_run;
            r_pending       <= n_pending;
            r_pending_start <= n_pending_start;
            r_phase         <= n_phase;
            r_found_start   <= n_found_start;
            r_found_end     <= n_found_end;
            r_ovf           <= n_ovf;
        end
    end

    always_comb begin
        n_pos           = r_pos;
        n_zero_run      = r_zero_run;
        n_pending       = r_pending;
        n_pending_start = r_pending_start;
        n_phase         = r_phase;
        n_found_start   = r_found_start;
        n_found_end     = r_found_end;
        n_ovf           = r_ovf;

        in_range = (r_pos < av1shl_pkg::MAX_STREAM_BYTES);
        hdr_type = i_byte[av1shl_pkg::OBU_TYPE_SHIFT +: av1shl_pkg::TYPE_W]
                   & av1shl_pkg::OBU_TYPE_MASK;
        back_off = (r_zero_run == av1shl_pkg::ZERO_RUN_MAX)
                   ? av1shl_pkg::START_W'(3) : av1shl_pkg::START_W'(2);

        if (i_step) begin
            if (!in_range) begin
                n_ovf = 1'b1;
            end

            // header byte of a pending start code
            if (r_pending) begin
                unique case (r_phase)
                    av1shl_pkg::PH_SEARCHING: begin
                        if (hdr_type == av1shl_pkg::OBU_SEQ_HEADER) begin
                            n_found_start = r_pending_start;
                            n_phase       = av1shl_pkg::PH_IN_SPAN;
                        end
                    end
                    av1shl_pkg::PH_IN_SPAN: begin
                        n_found_end = {1'b0, r_pending_start};
                        n_phase     = av1shl_pkg::PH_DONE;
                    end
                    av1shl_pkg::PH_DONE: begin
                    end
                    default: begin
                    end
                endcase
            end

            if (in_range && (i_byte == av1shl_pkg::BYTE_ONE)
                    && (r_zero_run >= av1shl_pkg::ZERO_RUN_CODE)) begin
                n_pending       = 1'b1;
                n_pending_start = r_pos[av1shl_pkg::START_W-1:0] - back_off;
            end else begin
                n_pending = 1'b0;
            end

            if (i_byte == av1shl_pkg::BYTE_ZERO) begin
                n_zero_run = (r_zero_run == av1shl_pkg::ZERO_RUN_MAX)
                             ? av1shl_pkg::ZERO_RUN_MAX : r_zero_run + 1'b1;
            end else begin
                n_zero_run = '0;
            end

            if (in_range) begin
                n_pos = r_pos + 1'b1;
            end
        end

        found                 = (n_phase != av1shl_pkg::PH_SEARCHING);
        o_result.header_found = found;
        o_result.span_start   = found ? n_found_start : '0;
        o_result.span_end     = !found ? '0 :
                                (n_phase == av1shl_pkg::PH_DONE) ? n_found_end : n_pos;
        o_result.too_long     = n_ovf;

        // end of stream: start over for the next one
        if (i_step && i_last) begin
            n_pos           = '0;
            n_zero_run      = '0;
            n_pending       = 1'b0;
            n_pending_start = '0;
            n_phase         = av1shl_pkg::PH_SEARCHING;
            n_found_start   = '0;
            n_found_end     = '0;
            n_ovf           = 1'b0;
        end
    end

endmodule
